@@ rtl/spc_pkg.sv @@
// Shared types and constants for the stroke pixel compositor.
// No dependencies; every other file but spc_udiv_pipe.sv imports this package.
package spc_pkg;

  localparam int CFG_INDEX_W = 3;

  localparam logic [23:0] CUBE_255  = 24'd16581375;
  localparam logic [22:0] HALF_CUBE = 23'd8290687;
  localparam logic [15:0] RECIP_255 = 16'h8081;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAINT_RED,
    CFG_PAINT_GREEN,
    CFG_PAINT_BLUE,
    CFG_PAINT_ALPHA,
    CFG_OPACITY,
    CFG_ERASE_MODE,
    CFG_CLIP_ENABLE
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] paint_red;
    logic [7:0] paint_green;
    logic [7:0] paint_blue;
    logic [7:0] paint_alpha;
    logic [7:0] opacity;
    logic       erase_mode;
    logic       clip_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t     pix;
    logic       m_zero;
    logic       s_zero;
    logic [7:0] erase_alpha;
    logic [7:0] blend_alpha;
  } blend_tag_t;

endpackage

@@ rtl/spc_channels.sv @@
// Channel interfaces: configuration writes, input pixel words, result words.
// Depends on spc_pkg.
interface spc_cfg_if import spc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface spc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] base_alpha;
  logic [7:0] coverage;
  logic [7:0] clip_value;

  modport source (output valid, base_red, base_green, base_blue, base_alpha, coverage,
                  clip_value, input ready);
  modport sink   (input valid, base_red, base_green, base_blue, base_alpha, coverage,
                  clip_value, output ready);
endinterface

interface spc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

@@ rtl/spc_cfg_regs.sv @@
// Configuration register bank for the compositor.
// Depends on spc_pkg and spc_cfg_if.
module spc_cfg_regs import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  spc_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.paint_red   <= 8'd0;
      regs.paint_green <= 8'd0;
      regs.paint_blue  <= 8'd0;
      regs.paint_alpha <= 8'd255;
      regs.opacity     <= 8'd255;
      regs.erase_mode  <= 1'b0;
      regs.clip_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_PAINT_RED:   regs.paint_red   <= cfg.data;
        CFG_PAINT_GREEN: regs.paint_green <= cfg.data;
        CFG_PAINT_BLUE:  regs.paint_blue  <= cfg.data;
        CFG_PAINT_ALPHA: regs.paint_alpha <= cfg.data;
        CFG_OPACITY:     regs.opacity     <= cfg.data;
        CFG_ERASE_MODE:  regs.erase_mode  <= cfg.data[0];
        CFG_CLIP_ENABLE: regs.clip_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/spc_udiv_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Depends on nothing; a tag word travels alongside.
module spc_udiv_pipe #(
  parameter int DEN_W = 24,
  parameter int QUO_W = 17,
  parameter int LANES = 1,
  parameter int TAG_W = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [LANES-1:0][DEN_W+QUO_W-1:0]     num,
  input  logic [DEN_W-1:0]                      den,
  input  logic [TAG_W-1:0]                      in_tag,
  output logic                                  out_valid,
  output logic [LANES-1:0][QUO_W-1:0]           quo,
  output logic [TAG_W-1:0]                      out_tag
);

  logic [QUO_W-1:0]                 vld;
  logic [DEN_W-1:0]                 den_q   [QUO_W];
  logic [TAG_W-1:0]                 tag_q   [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      rem_q   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      low_q   [QUO_W];
  logic [DEN_W-1:0]                 den_in  [QUO_W];
  logic [TAG_W-1:0]                 tag_in  [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      rem_next[QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      low_next[QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    if (i == 0) begin : g_head
      assign den_in[i] = den;
      assign tag_in[i] = in_tag;
    end else begin : g_body
      assign den_in[i] = den_q[i-1];
      assign tag_in[i] = tag_q[i-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W-1:0] rem_p;
      logic [QUO_W-1:0] low_p;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (i == 0) begin : g_load
        assign rem_p = num[l][DEN_W+QUO_W-1:QUO_W];
        assign low_p = num[l][QUO_W-1:0];
      end else begin : g_carry
        assign rem_p = rem_q[i-1][l];
        assign low_p = low_q[i-1][l];
      end

      assign trial = {rem_p, low_p[QUO_W-1]};
      assign ge    = trial >= {1'b0, den_in[i]};
      assign rem_next[i][l] = ge ? DEN_W'(trial - {1'b0, den_in[i]}) : trial[DEN_W-1:0];
      assign low_next[i][l] = {low_p[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QUO_W; i++) begin
        den_q[i] <= den_in[i];
        tag_q[i] <= tag_in[i];
        rem_q[i] <= rem_next[i];
        low_q[i] <= low_next[i];
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo       = low_q[QUO_W-1];
  assign out_tag   = tag_q[QUO_W-1];

endmodule

@@ rtl/spc_coverage.sv @@
// Effective coverage: coverage x opacity x clip, scaled to a fixed-point
// fraction by reciprocal multiplication and a remainder fix-up. Depends on spc_pkg.
module spc_coverage import spc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  pixel_t               pix,
  input  logic [7:0]           coverage,
  input  logic [7:0]           clip_value,
  input  cfg_t                 regs,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   m,
  output pixel_t               out_pix
);

  localparam int QUO_W = FRAC_BITS + 1;
  localparam int NUM_W = 24 + QUO_W;
  localparam int REM_W = 26;
  localparam logic [QUO_W-1:0] RECIP =
    QUO_W'((64'd1 << (FRAC_BITS + 24)) / 64'(CUBE_255));
  localparam logic [REM_W-1:0] CUBE_TWICE = REM_W'({CUBE_255, 1'b0});

  logic [6:0]       vld;
  logic [15:0]      p1;
  logic [7:0]       clip1;
  logic [23:0]      p2;
  logic [NUM_W-1:0] prod3;
  logic [NUM_W-1:0] n3;
  logic [QUO_W-1:0] q4;
  logic [NUM_W-1:0] n4;
  logic [NUM_W-1:0] qk5;
  logic [QUO_W-1:0] q5;
  logic [NUM_W-1:0] n5;
  logic [REM_W-1:0] r6;
  logic [QUO_W-1:0] q6;
  logic [QUO_W-1:0] m7;
  pixel_t           pix1;
  pixel_t           pix2;
  pixel_t           pix3;
  pixel_t           pix4;
  pixel_t           pix5;
  pixel_t           pix6;
  pixel_t           pix7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= 16'(coverage) * 16'(regs.opacity);
      clip1 <= regs.clip_enable ? clip_value : 8'hFF;
      pix1  <= pix;
      p2    <= 24'(p1) * 24'(clip1);
      pix2  <= pix1;
      prod3 <= NUM_W'(p2) * NUM_W'(RECIP);
      n3    <= (NUM_W'(p2) << FRAC_BITS) + NUM_W'(HALF_CUBE);
      pix3  <= pix2;
      q4    <= prod3[NUM_W-1:24];
      n4    <= n3;
      pix4  <= pix3;
      qk5   <= NUM_W'(q4) * NUM_W'(CUBE_255);
      q5    <= q4;
      n5    <= n4;
      pix5  <= pix4;
      r6    <= REM_W'(n5 - qk5);
      q6    <= q5;
      pix6  <= pix5;
      m7    <= q6 + QUO_W'(r6 >= REM_W'(CUBE_255)) + QUO_W'(r6 >= CUBE_TWICE);
      pix7  <= pix6;
    end
  end

  assign out_valid = vld[6];
  assign m         = m7;
  assign out_pix   = pix7;

endmodule

@@ rtl/spc_blend.sv @@
// Source-over blend and erase: alpha products, colour sums, then a
// three-lane divider for straight colour. Depends on spc_pkg, spc_udiv_pipe.
module spc_blend import spc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [FRAC_BITS:0]   m,
  input  pixel_t               pix,
  input  cfg_t                 regs,
  output logic                 out_valid,
  output pixel_t               res
);

  localparam int F   = FRAC_BITS;
  localparam int S_W = F + 8;
  localparam int A_W = F + 16;
  localparam int C_W = F + 24;
  localparam int Y_W = F + 17;
  localparam int X_W = F + 25;
  localparam logic [S_W-1:0] D_FULL     = {8'hFF, {F{1'b0}}};
  localparam logic [F+6:0]   ALPHA_HALF = {8'hFF, {(F-1){1'b0}}};
  localparam logic [F+8:0]   ONE_HALF   = (F+9)'(1) << (F - 1);

  logic [4:0]            vld;
  logic [2:0][7:0]       base_rgb;
  logic [2:0][7:0]       paint_rgb;

  logic [S_W-1:0]        s1;
  logic [S_W-1:0]        bam1;
  logic                  mz1;
  logic [2:0][15:0]      bba1;
  pixel_t                pix1;

  logic [F+8:0]          erase_sum;
  logic [S_W-1:0]        s2;
  logic [S_W-1:0]        dms2;
  logic [7:0]            ea2;
  logic                  sz2;
  logic                  mz2;
  logic [2:0][15:0]      bba2;
  pixel_t                pix2;

  logic [S_W-1:0]        s3;
  logic [A_W-1:0]        ab3;
  logic [2:0][A_W-1:0]   ps3;
  logic [2:0][C_W-1:0]   bd3;
  logic [7:0]            ea3;
  logic                  sz3;
  logic                  mz3;
  pixel_t                pix3;

  logic [A_W-1:0]        a4;
  logic [2:0][C_W-1:0]   c4;
  logic [7:0]            ea4;
  logic                  sz4;
  logic                  mz4;
  pixel_t                pix4;

  logic [Y_W-1:0]        alpha_sum;
  logic [2:0][X_W-1:0]   x5;
  logic [Y_W-1:0]        y5;
  logic [15:0]           t5;
  logic [7:0]            ea5;
  logic                  sz5;
  logic                  mz5;
  pixel_t                pix5;

  logic [31:0]           alpha_prod;
  blend_tag_t            tag_in;
  blend_tag_t            tag_out;
  logic [$bits(blend_tag_t)-1:0] tag_bits;
  logic [2:0][7:0]       quo;

  assign base_rgb  = {pix.blue, pix.green, pix.red};
  assign paint_rgb = {regs.paint_blue, regs.paint_green, regs.paint_red};
  assign erase_sum = {1'b0, pix1.alpha, {F{1'b0}}} - (F+9)'(bam1) + ONE_HALF;
  assign alpha_sum = Y_W'(a4) + Y_W'(ALPHA_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= S_W'(regs.paint_alpha) * S_W'(m);
      bam1 <= S_W'(pix.alpha) * S_W'(m);
      mz1  <= (m == '0);
      pix1 <= pix;
      for (int c = 0; c < 3; c++) begin
        bba1[c] <= 16'(base_rgb[c]) * 16'(pix.alpha);
      end

      s2   <= s1;
      dms2 <= D_FULL - s1;
      ea2  <= erase_sum[F+7:F];
      sz2  <= (s1 == '0);
      mz2  <= mz1;
      bba2 <= bba1;
      pix2 <= pix1;

      s3   <= s2;
      ab3  <= A_W'(pix2.alpha) * A_W'(dms2);
      for (int c = 0; c < 3; c++) begin
        ps3[c] <= A_W'(paint_rgb[c]) * A_W'(s2);
        bd3[c] <= C_W'(bba2[c]) * C_W'(dms2);
      end
      ea3  <= ea2;
      sz3  <= sz2;
      mz3  <= mz2;
      pix3 <= pix2;

      a4   <= (A_W'(s3) << 8) - A_W'(s3) + ab3;
      for (int c = 0; c < 3; c++) begin
        c4[c] <= (C_W'(ps3[c]) << 8) - C_W'(ps3[c]) + bd3[c];
      end
      ea4  <= ea3;
      sz4  <= sz3;
      mz4  <= mz3;
      pix4 <= pix3;

      for (int c = 0; c < 3; c++) begin
        x5[c] <= (X_W'(c4[c]) << 1) + X_W'(a4);
      end
      y5   <= {a4, 1'b0};
      t5   <= alpha_sum[F+15:F];
      ea5  <= ea4;
      sz5  <= sz4;
      mz5  <= mz4;
      pix5 <= pix4;
    end
  end

  assign alpha_prod = 32'(t5) * 32'(RECIP_255);

  always_comb begin
    tag_in.pix         = pix5;
    tag_in.m_zero      = mz5;
    tag_in.s_zero      = sz5;
    tag_in.erase_alpha = ea5;
    tag_in.blend_alpha = alpha_prod[30:23];
  end

  spc_udiv_pipe #(
    .DEN_W (Y_W),
    .QUO_W (8),
    .LANES (3),
    .TAG_W ($bits(blend_tag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[4]),
    .num       (x5),
    .den       (y5),
    .in_tag    (tag_in),
    .out_valid (out_valid),
    .quo       (quo),
    .out_tag   (tag_bits)
  );

  assign tag_out = blend_tag_t'(tag_bits);

  always_comb begin
    res = tag_out.pix;
    if (tag_out.m_zero) begin
      res = tag_out.pix;
    end else if (regs.erase_mode) begin
      res.alpha = tag_out.erase_alpha;
    end else if (!tag_out.s_zero) begin
      res.red   = quo[0];
      res.green = quo[1];
      res.blue  = quo[2];
      res.alpha = tag_out.blend_alpha;
    end
  end

endmodule

@@ rtl/stroke_pixel_composite_core.sv @@
// Stroke pixel compositor, straight-alpha RGBA, source-over or erase.
// Pipeline: 7 coverage stages, 5 blend stages, the 8 stage colour divider and the
// output register, between an input word and its result word.
// Throughput: one word per cycle unless the result side stalls; a skid register
// holds one word under stall.
// Reset clears all valid bits and loads the register defaults.
module stroke_pixel_composite_core import spc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  spc_cfg_if.sink       cfg,
  spc_pixel_if.sink     pixel,
  spc_result_if.source  result
);

  cfg_t                 regs;
  pixel_t               in_pix;
  pixel_t               cov_pix;
  logic [FRAC_BITS:0]   cov_m;
  logic                 cov_valid;
  logic                 blend_valid;
  pixel_t               blend_res;
  logic                 en;
  logic                 out_v;
  pixel_t               out_d;
  logic                 skid_v;
  pixel_t               skid_d;
  logic                 take;
  logic                 arrive;

  spc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign en          = !skid_v;
  assign pixel.ready = en && !rst;

  always_comb begin
    in_pix.red   = pixel.base_red;
    in_pix.green = pixel.base_green;
    in_pix.blue  = pixel.base_blue;
    in_pix.alpha = pixel.base_alpha;
  end

  spc_coverage #(.FRAC_BITS(FRAC_BITS)) u_coverage (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (pixel.valid),
    .pix        (in_pix),
    .coverage   (pixel.coverage),
    .clip_value (pixel.clip_value),
    .regs       (regs),
    .out_valid  (cov_valid),
    .m          (cov_m),
    .out_pix    (cov_pix)
  );

  spc_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cov_valid),
    .m         (cov_m),
    .pix       (cov_pix),
    .regs      (regs),
    .out_valid (blend_valid),
    .res       (blend_res)
  );

  assign take   = out_v && result.ready;
  assign arrive = blend_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_v || take) begin
        out_v <= 1'b1;
        out_d <= blend_res;
      end else begin
        skid_v <= 1'b1;
        skid_d <= blend_res;
      end
    end else if (take) begin
      out_v <= 1'b0;
    end
  end

  assign result.valid     = out_v;
  assign result.out_red   = out_d.red;
  assign result.out_green = out_d.green;
  assign result.out_blue  = out_d.blue;
  assign result.out_alpha = out_d.alpha;

endmodule

@@ bench/stroke_pixel_composite_core_test.sv @@
// Self-checking bench for stroke_pixel_composite_core: paint, erase and clip compositing.
// Depends on spc_pkg and the channel interfaces in spc_channels.sv.
module stroke_pixel_composite_core_test;
  import spc_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam longint unsigned CUBE = 64'd255 * 255 * 255;
  localparam longint unsigned FULL_D = 64'd255 * ONE_Q;
  localparam int SETTLE = FRAC_BITS + 24;
  localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = '1;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS = 172;

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] base_alpha;
    logic [7:0] coverage;
    logic [7:0] clip_value;
  } pixel_word_t;

  logic clk;
  logic rst;
  logic steady;
  int   mismatches = 0;
  cfg_t brush;
  pixel_t expected_pixels[$];

  spc_cfg_if    cfg_ch();
  spc_pixel_if  pix_ch();
  spc_result_if res_ch();

  stroke_pixel_composite_core #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch.sink),
    .pixel  (pix_ch.sink),
    .result (res_ch.source)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] blend_colour(input longint unsigned paint,
                                              input longint unsigned base,
                                              input longint unsigned base_a,
                                              input longint unsigned s,
                                              input longint unsigned a);
    longint unsigned c;
    c = 255 * paint * s + base * base_a * (FULL_D - s);
    return 8'((2 * c + a) / (2 * a));
  endfunction

  function automatic pixel_t composite_pixel(input pixel_word_t w);
    longint unsigned clip, p, m, s, a, ba;
    pixel_t o;
    o.red   = w.base_red;
    o.green = w.base_green;
    o.blue  = w.base_blue;
    o.alpha = w.base_alpha;
    ba   = 64'(w.base_alpha);
    clip = brush.clip_enable ? 64'(w.clip_value) : 64'd255;
    p    = 64'(w.coverage) * 64'(brush.opacity) * clip;
    m    = (p * ONE_Q + CUBE / 2) / CUBE;
    if (m == 0) return o;
    if (brush.erase_mode) begin
      o.alpha = 8'((ba * (ONE_Q - m) + ONE_Q / 2) >> FRAC_BITS);
      return o;
    end
    s = 64'(brush.paint_alpha) * m;
    if (s == 0) return o;
    a = 255 * s + ba * (FULL_D - s);
    o.red   = blend_colour(64'(brush.paint_red), 64'(w.base_red), ba, s, a);
    o.green = blend_colour(64'(brush.paint_green), 64'(w.base_green), ba, s, a);
    o.blue  = blend_colour(64'(brush.paint_blue), 64'(w.base_blue), ba, s, a);
    o.alpha = 8'((2 * a + FULL_D) / (2 * FULL_D));
    return o;
  endfunction

  function automatic pixel_word_t pix(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic [7:0] a,
                                      input logic [7:0] cov, input logic [7:0] clip);
    pixel_word_t w;
    w = '{r, g, b, a, cov, clip};
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic pixel_word_t random_pixel();
    return pix(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endfunction

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with no pixel outstanding");
          mismatches++;
        end else begin
          pixel_t exp_p;
          exp_p = expected_pixels.pop_front();
          report_field("out_red", exp_p.red, res_ch.out_red);
          report_field("out_green", exp_p.green, res_ch.out_green);
          report_field("out_blue", exp_p.blue, res_ch.out_blue);
          report_field("out_alpha", exp_p.alpha, res_ch.out_alpha);
        end
      end
      res_ch.ready <= steady || ($urandom_range(99) >= 19);
    end
  end

  task automatic send_pixel(input pixel_word_t w);
    while (!steady && $urandom_range(99) < 19) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.base_red   <= w.base_red;
    pix_ch.base_green <= w.base_green;
    pix_ch.base_blue  <= w.base_blue;
    pix_ch.base_alpha <= w.base_alpha;
    pix_ch.coverage   <= w.coverage;
    pix_ch.clip_value <= w.clip_value;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    expected_pixels.push_back(composite_pixel(w));
  endtask

  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_PAINT_RED:   brush.paint_red   = value;
      CFG_PAINT_GREEN: brush.paint_green = value;
      CFG_PAINT_BLUE:  brush.paint_blue  = value;
      CFG_PAINT_ALPHA: brush.paint_alpha = value;
      CFG_OPACITY:     brush.opacity     = value;
      CFG_ERASE_MODE:  brush.erase_mode  = value[0];
      CFG_CLIP_ENABLE: brush.clip_enable = value[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_brush(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input logic [7:0] op,
                             input logic [7:0] erase, input logic [7:0] clip);
    write_reg(CFG_PAINT_RED, r);
    write_reg(CFG_PAINT_GREEN, g);
    write_reg(CFG_PAINT_BLUE, b);
    write_reg(CFG_PAINT_ALPHA, a);
    write_reg(CFG_OPACITY, op);
    write_reg(CFG_ERASE_MODE, erase);
    write_reg(CFG_CLIP_ENABLE, clip);
  endtask

  task automatic test_reset_defaults();
    send_pixel(pix(8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 8'd0));
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_pixel(pix(8'd200, 8'd100, 8'd50, 8'd0, 8'd1, 8'hFF));
    send_pixel(pix(8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd7));
    drain_results();
  endtask

  task automatic test_paint_extremes();
    write_brush(8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_pixel(pix(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_pixel(pix(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00));
    send_pixel(pix(8'h12, 8'h34, 8'h56, 8'hFF, 8'h01, 8'hFF));
    drain_results();
    write_brush(8'd1, 8'd254, 8'd127, 8'd1, 8'd1, 8'h00, 8'h00);
    send_pixel(pix(8'hFF, 8'h00, 8'hAA, 8'h01, 8'hFF, 8'h00));
    send_pixel(pix(8'h55, 8'hAA, 8'h55, 8'h00, 8'h01, 8'h00));
    send_pixel(pix(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
    drain_results();
  endtask

  task automatic test_transparent_paint();
    write_reg(CFG_PAINT_ALPHA, 8'h00);
    write_reg(CFG_OPACITY, 8'hFF);
    send_pixel(pix(8'h11, 8'h22, 8'h33, 8'h44, 8'hFF, 8'hFF));
    send_pixel(pix(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00));
    drain_results();
  endtask

  task automatic test_erase();
    write_brush(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00);
    send_pixel(pix(8'h10, 8'h20, 8'h30, 8'hFF, 8'hFF, 8'h00));
    send_pixel(pix(8'h10, 8'h20, 8'h30, 8'hFF, 8'h80, 8'h00));
    send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h00));
    send_pixel(pix(8'h01, 8'h02, 8'h03, 8'h7F, 8'h00, 8'hFF));
    drain_results();
  endtask

  task automatic test_clip();
    write_brush(8'h40, 8'hC0, 8'h20, 8'hFF, 8'hC0, 8'h00, 8'h01);
    send_pixel(pix(8'h90, 8'h10, 8'hE0, 8'hFF, 8'hFF, 8'h00));
    send_pixel(pix(8'h90, 8'h10, 8'hE0, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pix(8'h90, 8'h10, 8'hE0, 8'h40, 8'hFF, 8'h01));
    send_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01));
    drain_results();
  endtask

  task automatic test_register_masking();
    write_reg(CFG_ERASE_MODE, 8'hFE);
    write_reg(CFG_CLIP_ENABLE, 8'h03);
    write_reg(UNUSED_INDEX, 8'h55);
    send_pixel(pix(8'h33, 8'h66, 8'h99, 8'hCC, 8'hF0, 8'h80));
    send_pixel(pix(8'hCC, 8'h99, 8'h66, 8'h33, 8'h80, 8'hF0));
    drain_results();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_brush(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01);
        1: write_brush(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00);
        default: write_brush(pick_byte(), pick_byte(), pick_byte(),
                             ($urandom_range(5) == 0) ? 8'h00 : pick_byte(), pick_byte(),
                             8'(($urandom_range(2) == 0) ? $urandom_range(255) | 1 :
                                                             $urandom_range(255) & 8'hFE),
                             8'($urandom_range(255)));
      endcase
      steady = (phase == 3);
      for (int i = 0; i < PHASE_WORDS; i++) send_pixel(random_pixel());
      drain_results();
      steady = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    steady = 1'b0;
    brush = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0};
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.base_red = '0;
    pix_ch.base_green = '0;
    pix_ch.base_blue = '0;
    pix_ch.base_alpha = '0;
    pix_ch.coverage = '0;
    pix_ch.clip_value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_paint_extremes();
    test_transparent_paint();
    test_erase();
    test_clip();
    test_register_masking();
    test_random_stream();
    if (expected_pixels.size() != 0) begin
      $error("%0d pixels never produced a result", expected_pixels.size());
    end
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
